/* src/lsps_pkg.sv */
// Shared types and constants for the line sensor PD steering block.
// No dependencies; used by every module under src.
package lsps_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_W     = 10;
    localparam int GAIN_W       = 10;
    localparam int BASE_W       = 10;
    localparam int FLOOR_W      = 9;
    localparam int THRESH_W     = 10;
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int ESUM_W       = 7;
    localparam int DIFF_W       = ESUM_W + 1;
    localparam int TERM_W       = 18;
    localparam int PDSUM_W      = TERM_W + 1;
    localparam int ACC_W        = PDSUM_W + 6;
    localparam int SPEED_W      = 15;
    localparam int NUM_STAGES   = 7;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [SAMPLE_W-1:0] TRACK_RESET = SAMPLE_W'(500);
    localparam logic [THRESH_W-1:0] FULL_SCALE  = THRESH_W'(1000);

    localparam logic signed [ESUM_W-1:0] WEIGHT_TENTHS [SENSOR_COUNT] = '{
        7'sd0, -7'sd22, -7'sd15, -7'sd10, 7'sd0, 7'sd10, 7'sd15, 7'sd22
    };

    localparam logic [GAIN_W-1:0]   KP_RESET     = GAIN_W'(154);
    localparam logic [GAIN_W-1:0]   KD_RESET     = GAIN_W'(41);
    localparam logic [BASE_W-1:0]   BASE_RESET   = BASE_W'(400);
    localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = FLOOR_W'(40);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(70);

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 15'sd16383;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -15'sd16384;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KD     = 3'd1,
        REG_BASE   = 3'd2,
        REG_FLOOR  = 3'd3,
        REG_THRESH = 3'd4
    } reg_idx_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                  accept;
        logic                  prev_upd;
        logic [NUM_STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

/* src/lsps_lane.sv */
// One sensor lane: running min/max tracking and the on-line judgment.
// Depends on lsps_pkg; instantiated once per sensor by the top level.
module lsps_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lsps_pkg::pipe_ctrl_t              ctrl,
    input  lsps_pkg::sample_t                 sample,
    input  logic [lsps_pkg::FLOOR_W-1:0]      floor_offset,
    input  logic [lsps_pkg::THRESH_W-1:0]     on_threshold,
    output logic                              on_line
);

    lsps_pkg::sample_t                  low_reg, high_reg, samp_reg;
    lsps_pkg::sample_t                  low_next, high_next;
    lsps_pkg::sample_t                  level, span;
    logic [lsps_pkg::PROD_W-1:0]        lhs_reg, rhs_reg;
    logic                               off_reg, on_reg;
    logic                               off_next;

    always_comb begin
        low_next  = (sample < low_reg)  ? sample : low_reg;
        high_next = (sample > high_reg) ? sample : high_reg;
        level     = samp_reg - low_reg;
        span      = high_reg - lsps_pkg::SAMPLE_W'(floor_offset);
        off_next  = (on_threshold > lsps_pkg::FULL_SCALE) ||
                    ((on_threshold != '0) &&
                     (high_reg <= lsps_pkg::SAMPLE_W'(floor_offset)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= lsps_pkg::TRACK_RESET;
            high_reg <= lsps_pkg::TRACK_RESET;
        end else if (ctrl.accept) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // stage 0 sample; tracks already hold this item's update
    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            samp_reg <= sample;
        end
        if (ctrl.en[1]) begin
            lhs_reg <= lsps_pkg::PROD_W'(level) *
                       lsps_pkg::PROD_W'(lsps_pkg::FULL_SCALE);
            rhs_reg <= lsps_pkg::PROD_W'(on_threshold) * lsps_pkg::PROD_W'(span);
            off_reg <= off_next;
        end
        if (ctrl.en[2]) begin
            on_reg <= !off_reg && (lhs_reg >= rhs_reg);
        end
    end

    assign on_line = on_reg;

endmodule

/* src/lsps_merge.sv */
// Merging stage: collects the lane flags into a mask and a weighted error sum.
// Depends on lsps_pkg; keeps the previous error for the derivative term.
module lsps_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lsps_pkg::pipe_ctrl_t                   ctrl,
    input  logic [lsps_pkg::SENSOR_COUNT-1:0]      on_vec,
    output logic [lsps_pkg::SENSOR_COUNT-1:0]      mask,
    output logic signed [lsps_pkg::ESUM_W-1:0]     esum,
    output logic signed [lsps_pkg::DIFF_W-1:0]     ediff
);

    logic [lsps_pkg::SENSOR_COUNT-1:0]   mask_reg;
    logic signed [lsps_pkg::ESUM_W-1:0]  esum_reg, prev_reg;
    logic signed [lsps_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [lsps_pkg::DIFF_W-1:0]  acc;
    logic signed [lsps_pkg::ESUM_W-1:0]  esum_next;

    always_comb begin
        acc = '0;
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
            if (on_vec[i]) begin
                acc = acc + lsps_pkg::DIFF_W'(lsps_pkg::WEIGHT_TENTHS[i]);
            end
        end
        esum_next = acc[lsps_pkg::ESUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (ctrl.prev_upd) begin
            prev_reg <= esum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            mask_reg <= on_vec;
            esum_reg <= esum_next;
            diff_reg <= lsps_pkg::DIFF_W'(esum_next) - lsps_pkg::DIFF_W'(prev_reg);
        end
    end

    assign mask  = mask_reg;
    assign esum  = esum_reg;
    assign ediff = diff_reg;

endmodule

/* src/lsps_pd.sv */
// PD steering stages: gain products, scaling by 100, shift and wheel saturation.
// Depends on lsps_pkg; fed by the merging stage.
module lsps_pd #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                                   aclk,
    input  lsps_pkg::pipe_ctrl_t                   ctrl,
    input  logic [lsps_pkg::GAIN_W-1:0]            kp_gain,
    input  logic [lsps_pkg::GAIN_W-1:0]            kd_gain,
    input  logic [lsps_pkg::BASE_W-1:0]            base_speed,
    input  logic [lsps_pkg::SENSOR_COUNT-1:0]      mask_in,
    input  logic signed [lsps_pkg::ESUM_W-1:0]     esum_in,
    input  logic signed [lsps_pkg::DIFF_W-1:0]     ediff_in,
    output logic signed [lsps_pkg::SPEED_W-1:0]    right_speed,
    output logic signed [lsps_pkg::SPEED_W-1:0]    left_speed,
    output logic [lsps_pkg::SENSOR_COUNT-1:0]      mask_out,
    output logic signed [lsps_pkg::ESUM_W-1:0]     esum_out
);

    localparam int OUT_W = lsps_pkg::ACC_W + 1;

    logic signed [lsps_pkg::TERM_W-1:0]   pterm_reg, dterm_reg;
    logic signed [lsps_pkg::TERM_W-1:0]   kp_s, kd_s, e_s, d_s;
    logic signed [lsps_pkg::PDSUM_W-1:0]  pdsum;
    logic signed [lsps_pkg::ACC_W-1:0]    pdsum_x, acc_reg, pd;
    logic signed [OUT_W-1:0]              rsum, lsum;
    logic [lsps_pkg::SENSOR_COUNT-1:0]    mask5_reg, mask6_reg, mask7_reg;
    logic signed [lsps_pkg::ESUM_W-1:0]   esum5_reg, esum6_reg, esum7_reg;
    logic signed [lsps_pkg::SPEED_W-1:0]  right_reg, left_reg;

    function automatic logic signed [lsps_pkg::SPEED_W-1:0] sat_speed(
        input logic signed [OUT_W-1:0] v
    );
        if (v > OUT_W'(lsps_pkg::SPEED_MAX)) begin
            return lsps_pkg::SPEED_MAX;
        end else if (v < OUT_W'(lsps_pkg::SPEED_MIN)) begin
            return lsps_pkg::SPEED_MIN;
        end
        return v[lsps_pkg::SPEED_W-1:0];
    endfunction

    always_comb begin
        kp_s    = $signed({{(lsps_pkg::TERM_W-lsps_pkg::GAIN_W){1'b0}}, kp_gain});
        kd_s    = $signed({{(lsps_pkg::TERM_W-lsps_pkg::GAIN_W){1'b0}}, kd_gain});
        e_s     = lsps_pkg::TERM_W'(esum_in);
        d_s     = lsps_pkg::TERM_W'(ediff_in);
        pdsum   = lsps_pkg::PDSUM_W'(pterm_reg) + lsps_pkg::PDSUM_W'(dterm_reg);
        pdsum_x = lsps_pkg::ACC_W'(pdsum);
        pd      = acc_reg >>> GAIN_FRAC_BITS;
        rsum    = $signed({{(OUT_W-lsps_pkg::BASE_W){1'b0}}, base_speed}) + OUT_W'(pd);
        lsum    = $signed({{(OUT_W-lsps_pkg::BASE_W){1'b0}}, base_speed}) - OUT_W'(pd);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            pterm_reg <= kp_s * e_s;
            dterm_reg <= kd_s * d_s;
            mask5_reg <= mask_in;
            esum5_reg <= esum_in;
        end
        if (ctrl.en[5]) begin
            // x100 = x64 + x32 + x4
            acc_reg   <= (pdsum_x <<< 6) + (pdsum_x <<< 5) + (pdsum_x <<< 2);
            mask6_reg <= mask5_reg;
            esum6_reg <= esum5_reg;
        end
        if (ctrl.en[6]) begin
            right_reg <= sat_speed(rsum);
            left_reg  <= sat_speed(lsum);
            mask7_reg <= mask6_reg;
            esum7_reg <= esum6_reg;
        end
    end

    assign right_speed = right_reg;
    assign left_speed  = left_reg;
    assign mask_out    = mask7_reg;
    assign esum_out    = esum7_reg;

endmodule

/* src/line_sensor_pd_steering.sv */
// Top level of the line sensor PD steering block: APB registers, pipeline
// control, eight sensor lanes, merging stage and PD stages.
// Depends on lsps_pkg, lsps_lane, lsps_merge and lsps_pd.
//
// The block takes one item of eight samples per clock cycle while s_ready is
// high, and returns one result per item from a seven-stage pipeline: sample
// capture, per-lane products, per-lane compare, weighted merge, gain products,
// scaling and the shift/saturate output register. Every stage holds under
// output backpressure and bubbles are squeezed out, so s_ready stays high
// whenever the pipeline has a free slot. Min/max tracking is updated as items
// are accepted. Registers must be written only while the block is idle; the
// block itself does not enforce this.
module line_sensor_pd_steering #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsps_pkg::ADDR_W-1:0]          paddr,
    input  logic [lsps_pkg::DATA_W-1:0]          pwdata,
    output logic [lsps_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_0,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_1,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_2,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_3,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_4,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_5,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_6,
    input  logic [lsps_pkg::SAMPLE_W-1:0]        s_sample_7,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lsps_pkg::SPEED_W-1:0]  m_right_speed,
    output logic signed [lsps_pkg::SPEED_W-1:0]  m_left_speed,
    output logic [lsps_pkg::SENSOR_COUNT-1:0]    m_online_mask,
    output logic signed [lsps_pkg::ESUM_W-1:0]   m_weighted_sum
);

    localparam int NS = lsps_pkg::NUM_STAGES;

    logic [lsps_pkg::GAIN_W-1:0]          kp_gain_reg, kd_gain_reg;
    logic [lsps_pkg::BASE_W-1:0]          base_speed_reg;
    logic [lsps_pkg::FLOOR_W-1:0]         floor_offset_reg;
    logic [lsps_pkg::THRESH_W-1:0]        on_threshold_reg;
    logic                                 cfg_wr;

    logic [NS-1:0]                        vld_reg;
    logic [NS-1:0]                        en;
    lsps_pkg::pipe_ctrl_t                 ctrl;

    lsps_pkg::sample_t                    samples [lsps_pkg::SENSOR_COUNT];
    logic [lsps_pkg::SENSOR_COUNT-1:0]    on_vec;
    logic [lsps_pkg::SENSOR_COUNT-1:0]    mask4;
    logic signed [lsps_pkg::ESUM_W-1:0]   esum4;
    logic signed [lsps_pkg::DIFF_W-1:0]   diff4;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg      <= lsps_pkg::KP_RESET;
            kd_gain_reg      <= lsps_pkg::KD_RESET;
            base_speed_reg   <= lsps_pkg::BASE_RESET;
            floor_offset_reg <= lsps_pkg::FLOOR_RESET;
            on_threshold_reg <= lsps_pkg::THRESH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                lsps_pkg::REG_KP:     kp_gain_reg      <= pwdata[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_KD:     kd_gain_reg      <= pwdata[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_BASE:   base_speed_reg   <= pwdata[lsps_pkg::BASE_W-1:0];
                lsps_pkg::REG_FLOOR:  floor_offset_reg <= pwdata[lsps_pkg::FLOOR_W-1:0];
                lsps_pkg::REG_THRESH: on_threshold_reg <= pwdata[lsps_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            lsps_pkg::REG_KP:     prdata = lsps_pkg::DATA_W'(kp_gain_reg);
            lsps_pkg::REG_KD:     prdata = lsps_pkg::DATA_W'(kd_gain_reg);
            lsps_pkg::REG_BASE:   prdata = lsps_pkg::DATA_W'(base_speed_reg);
            lsps_pkg::REG_FLOOR:  prdata = lsps_pkg::DATA_W'(floor_offset_reg);
            lsps_pkg::REG_THRESH: prdata = lsps_pkg::DATA_W'(on_threshold_reg);
            default:              prdata = '0;
        endcase
    end

    // pipeline control: a stage loads when empty or when it moves on
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        ctrl.en       = en;
        ctrl.accept   = s_valid && en[0];
        ctrl.prev_upd = en[3] && vld_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NS-1];

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    for (genvar i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin : g_lane
        lsps_lane u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .sample       (samples[i]),
            .floor_offset (floor_offset_reg),
            .on_threshold (on_threshold_reg),
            .on_line      (on_vec[i])
        );
    end

    lsps_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .on_vec  (on_vec),
        .mask    (mask4),
        .esum    (esum4),
        .ediff   (diff4)
    );

    lsps_pd #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pd (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .kp_gain     (kp_gain_reg),
        .kd_gain     (kd_gain_reg),
        .base_speed  (base_speed_reg),
        .mask_in     (mask4),
        .esum_in     (esum4),
        .ediff_in    (diff4),
        .right_speed (m_right_speed),
        .left_speed  (m_left_speed),
        .mask_out    (m_online_mask),
        .esum_out    (m_weighted_sum)
    );

endmodule

/* bench/tb_line_sensor_pd_steering.sv */
// Self-checking testbench for line_sensor_pd_steering: drives sensor items and
// APB register writes, predicts each wheel command and compares it on the fly.
// Depends on lsps_pkg and the line_sensor_pd_steering RTL.
module tb_line_sensor_pd_steering;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAIN_FRAC      = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_HOLD      = 300;
    localparam int REG_SPARE_LO   = int'(lsps_pkg::REG_THRESH) + 1;
    localparam int REG_SPARE_HI   = (1 << $bits(lsps_pkg::reg_idx_t)) - 1;
    localparam int SAMPLE_MAX     = (1 << lsps_pkg::SAMPLE_W) - 1;

    typedef lsps_pkg::sample_t sample_row_t [lsps_pkg::SENSOR_COUNT];

    typedef struct {
        logic signed [lsps_pkg::SPEED_W-1:0] right_speed;
        logic signed [lsps_pkg::SPEED_W-1:0] left_speed;
        logic [lsps_pkg::SENSOR_COUNT-1:0]   online_mask;
        logic signed [lsps_pkg::ESUM_W-1:0]  weighted_sum;
    } wheel_cmd_t;

    class steering_scoreboard;
        logic [lsps_pkg::GAIN_W-1:0]         kp;
        logic [lsps_pkg::GAIN_W-1:0]         kd;
        logic [lsps_pkg::BASE_W-1:0]         base;
        logic [lsps_pkg::FLOOR_W-1:0]        floor_ofs;
        logic [lsps_pkg::THRESH_W-1:0]       thresh;
        lsps_pkg::sample_t                   low_trk [lsps_pkg::SENSOR_COUNT];
        lsps_pkg::sample_t                   high_trk [lsps_pkg::SENSOR_COUNT];
        logic signed [lsps_pkg::ESUM_W-1:0]  prev_sum;
        wheel_cmd_t                          expected_cmds [$];
        int                                  errors;
        int                                  items_seen;
        int                                  cmds_matched;

        function new();
            kp        = lsps_pkg::KP_RESET;
            kd        = lsps_pkg::KD_RESET;
            base      = lsps_pkg::BASE_RESET;
            floor_ofs = lsps_pkg::FLOOR_RESET;
            thresh    = lsps_pkg::THRESH_RESET;
            foreach (low_trk[i]) begin
                low_trk[i]  = lsps_pkg::TRACK_RESET;
                high_trk[i] = lsps_pkg::TRACK_RESET;
            end
            prev_sum     = '0;
            errors       = 0;
            items_seen   = 0;
            cmds_matched = 0;
        endfunction

        function void set_reg(int idx, logic [lsps_pkg::DATA_W-1:0] value);
            case (idx)
                lsps_pkg::REG_KP:     kp        = value[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_KD:     kd        = value[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::REG_BASE:   base      = value[lsps_pkg::BASE_W-1:0];
                lsps_pkg::REG_FLOOR:  floor_ofs = value[lsps_pkg::FLOOR_W-1:0];
                lsps_pkg::REG_THRESH: thresh    = value[lsps_pkg::THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(sample_row_t smp);
            wheel_cmd_t cmd;
            int         esum;
            int         level;
            int         span;
            bit         on;
            longint     pd;
            longint     rs;
            longint     ls;
            esum = 0;
            cmd.online_mask = '0;
            for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
                if (smp[i] < low_trk[i]) low_trk[i] = smp[i];
                if (smp[i] > high_trk[i]) high_trk[i] = smp[i];
                if (thresh > lsps_pkg::FULL_SCALE) begin
                    on = 1'b0;
                end else if (thresh == 0) begin
                    on = 1'b1;
                end else if (high_trk[i] <= floor_ofs) begin
                    on = 1'b0;
                end else begin
                    level = int'(smp[i]) - int'(low_trk[i]);
                    span  = int'(high_trk[i]) - int'(floor_ofs);
                    on = longint'(level) * longint'(lsps_pkg::FULL_SCALE) >=
                         longint'(thresh) * longint'(span);
                end
                if (on) begin
                    cmd.online_mask[i] = 1'b1;
                    esum += int'(lsps_pkg::WEIGHT_TENTHS[i]);
                end
            end
            pd = longint'(kp) * esum + longint'(kd) * (esum - int'(prev_sum));
            pd = (pd * 100) >>> GAIN_FRAC;
            rs = longint'(base) + pd;
            ls = longint'(base) - pd;
            if (rs > lsps_pkg::SPEED_MAX) rs = lsps_pkg::SPEED_MAX;
            if (rs < lsps_pkg::SPEED_MIN) rs = lsps_pkg::SPEED_MIN;
            if (ls > lsps_pkg::SPEED_MAX) ls = lsps_pkg::SPEED_MAX;
            if (ls < lsps_pkg::SPEED_MIN) ls = lsps_pkg::SPEED_MIN;
            cmd.right_speed  = rs[lsps_pkg::SPEED_W-1:0];
            cmd.left_speed   = ls[lsps_pkg::SPEED_W-1:0];
            cmd.weighted_sum = esum[lsps_pkg::ESUM_W-1:0];
            prev_sum = esum[lsps_pkg::ESUM_W-1:0];
            expected_cmds.push_back(cmd);
            items_seen++;
        endfunction

        function void check_result(wheel_cmd_t got);
            wheel_cmd_t exp_cmd;
            bit         ok;
            if (expected_cmds.size() == 0) begin
                $error("wheel command with no item outstanding");
                errors++;
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            ok = 1'b1;
            if (got.right_speed !== exp_cmd.right_speed) begin
                $error("right_speed: expected %0d, got %0d",
                       exp_cmd.right_speed, got.right_speed);
                ok = 1'b0;
            end
            if (got.left_speed !== exp_cmd.left_speed) begin
                $error("left_speed: expected %0d, got %0d",
                       exp_cmd.left_speed, got.left_speed);
                ok = 1'b0;
            end
            if (got.online_mask !== exp_cmd.online_mask) begin
                $error("online_mask: expected %b, got %b",
                       exp_cmd.online_mask, got.online_mask);
                ok = 1'b0;
            end
            if (got.weighted_sum !== exp_cmd.weighted_sum) begin
                $error("weighted_sum: expected %0d, got %0d",
                       exp_cmd.weighted_sum, got.weighted_sum);
                ok = 1'b0;
            end
            if (ok) cmds_matched++;
            else errors++;
        endfunction
    endclass

    logic                                 aclk    = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 psel    = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite  = 1'b0;
    logic [lsps_pkg::ADDR_W-1:0]          paddr   = '0;
    logic [lsps_pkg::DATA_W-1:0]          pwdata  = '0;
    logic [lsps_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    lsps_pkg::sample_t                    s_sample_0 = '0;
    lsps_pkg::sample_t                    s_sample_1 = '0;
    lsps_pkg::sample_t                    s_sample_2 = '0;
    lsps_pkg::sample_t                    s_sample_3 = '0;
    lsps_pkg::sample_t                    s_sample_4 = '0;
    lsps_pkg::sample_t                    s_sample_5 = '0;
    lsps_pkg::sample_t                    s_sample_6 = '0;
    lsps_pkg::sample_t                    s_sample_7 = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [lsps_pkg::SPEED_W-1:0]  m_right_speed;
    logic signed [lsps_pkg::SPEED_W-1:0]  m_left_speed;
    logic [lsps_pkg::SENSOR_COUNT-1:0]    m_online_mask;
    logic signed [lsps_pkg::ESUM_W-1:0]   m_weighted_sum;

    steering_scoreboard sb = new();

    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    bit          long_hold_req = 1'b0;
    int          hold_left     = 0;
    int          settings_used = 0;
    sample_row_t seen_row;
    wheel_cmd_t  seen_cmd;

    line_sensor_pd_steering #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_0    (s_sample_0),
        .s_sample_1    (s_sample_1),
        .s_sample_2    (s_sample_2),
        .s_sample_3    (s_sample_3),
        .s_sample_4    (s_sample_4),
        .s_sample_5    (s_sample_5),
        .s_sample_6    (s_sample_6),
        .s_sample_7    (s_sample_7),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_right_speed (m_right_speed),
        .m_left_speed  (m_left_speed),
        .m_online_mask (m_online_mask),
        .m_weighted_sum(m_weighted_sum)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            seen_row[0] = s_sample_0;
            seen_row[1] = s_sample_1;
            seen_row[2] = s_sample_2;
            seen_row[3] = s_sample_3;
            seen_row[4] = s_sample_4;
            seen_row[5] = s_sample_5;
            seen_row[6] = s_sample_6;
            seen_row[7] = s_sample_7;
            sb.note_item(seen_row);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_cmd.right_speed  = m_right_speed;
            seen_cmd.left_speed   = m_left_speed;
            seen_cmd.online_mask  = m_online_mask;
            seen_cmd.weighted_sum = m_weighted_sum;
            sb.check_result(seen_cmd);
        end
    end

    // result side: random stalls plus one long hold-off in the first phase
    always @(posedge aclk) begin
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_item(input sample_row_t smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_sample_0 <= smp[0];
        s_sample_1 <= smp[1];
        s_sample_2 <= smp[2];
        s_sample_3 <= smp[3];
        s_sample_4 <= smp[4];
        s_sample_5 <= smp[5];
        s_sample_6 <= smp[6];
        s_sample_7 <= smp[7];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_cmds.size() != 0) @(posedge aclk);
        repeat (lsps_pkg::NUM_STAGES + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [lsps_pkg::DATA_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsps_pkg::ADDR_W'(idx << 2);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic apply_settings(input int kp, input int kd, input int base,
                                  input int flr, input int thr);
        write_reg(lsps_pkg::REG_KP, kp);
        write_reg(lsps_pkg::REG_KD, kd);
        write_reg(lsps_pkg::REG_BASE, base);
        write_reg(lsps_pkg::REG_FLOOR, flr);
        write_reg(lsps_pkg::REG_THRESH, thr);
        settings_used++;
    endtask

    task automatic send_fill(input int value);
        sample_row_t smp;
        foreach (smp[i]) smp[i] = lsps_pkg::sample_t'(value);
        send_item(smp);
    endtask

    task automatic send_spot(input int idx, input int hi, input int lo);
        sample_row_t smp;
        foreach (smp[i]) smp[i] = lsps_pkg::sample_t'((i == idx) ? hi : lo);
        send_item(smp);
    endtask

    function automatic sample_row_t make_item();
        sample_row_t smp;
        int          kind;
        int          center;
        int          half;
        int          bg;
        int          fg;
        int          gap;
        int          lvl;
        int          sel;
        kind   = $urandom_range(99);
        center = $urandom_range(lsps_pkg::SENSOR_COUNT - 1);
        half   = $urandom_range(1);
        bg     = $urandom_range(250);
        fg     = $urandom_range(SAMPLE_MAX, 600);
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
            if (kind < 70) begin
                // dark line over a light floor, with noise
                gap = (i > center) ? i - center : center - i;
                lvl = ((gap <= half) ? fg : bg) + int'($urandom_range(60)) - 30;
                if (lvl < 0) lvl = 0;
                if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
                smp[i] = lsps_pkg::sample_t'(lvl);
            end else if (kind < 88) begin
                smp[i] = lsps_pkg::sample_t'($urandom_range(SAMPLE_MAX));
            end else if (kind < 96) begin
                sel = $urandom_range(2);
                smp[i] = (sel == 0) ? lsps_pkg::sample_t'(0) :
                         (sel == 1) ? lsps_pkg::sample_t'(SAMPLE_MAX) :
                                      lsps_pkg::sample_t'($urandom_range(SAMPLE_MAX));
            end else begin
                smp[i] = lsps_pkg::sample_t'(bg * 4);
            end
        end
        return smp;
    endfunction

    initial begin
        #5ms;
        $error("timeout: block stopped making progress");
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, samples kept at or below the reset track level
        send_fill(0);
        send_fill(250);
        send_spot(3, 480, 0);
        send_spot(6, 500, 20);

        // floor above every tracked max: sensors off until one rises above it
        write_reg(lsps_pkg::REG_FLOOR, 511);
        send_fill(100);
        send_fill(300);
        send_spot(2, 700, 0);

        // zero threshold: all on
        write_reg(lsps_pkg::REG_THRESH, 0);
        send_fill(SAMPLE_MAX);
        send_fill(0);

        // threshold above full scale, then exactly full scale
        write_reg(lsps_pkg::REG_THRESH, SAMPLE_MAX);
        send_fill(512);
        write_reg(lsps_pkg::REG_THRESH, lsps_pkg::FULL_SCALE);
        send_fill(SAMPLE_MAX);
        send_spot(5, 0, SAMPLE_MAX);

        write_reg(lsps_pkg::REG_FLOOR, lsps_pkg::FLOOR_RESET);
        write_reg(lsps_pkg::REG_THRESH, lsps_pkg::THRESH_RESET);
        send_fill('h2AA);
        send_fill('h155);
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) send_spot(i, SAMPLE_MAX, 0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings(lsps_pkg::KP_RESET, lsps_pkg::KD_RESET,
                                  lsps_pkg::BASE_RESET, lsps_pkg::FLOOR_RESET,
                                  lsps_pkg::THRESH_RESET);
                1: apply_settings(1023, 1023, 1023, 0, lsps_pkg::FULL_SCALE);
                2: apply_settings(0, 0, 0, 511, 1);
                3: begin
                    apply_settings(1023, 0, 512, 499, 0);
                    write_reg(REG_SPARE_LO, $urandom);
                    write_reg(REG_SPARE_HI, $urandom);
                end
                4: apply_settings(0, 1023, 1, 100, 1023);
                7: apply_settings(512, 300, 300, 200, 500);
                default: apply_settings($urandom_range(1023), $urandom_range(1023),
                                        $urandom_range(1023), $urandom_range(511),
                                        $urandom_range(1023));
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            // back up the pipeline while the sender keeps pushing
            if (p == 0) long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_item(make_item());
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        drain();

        $display("Sent %0d sensor items under %0d register settings plus edge cases;",
                 sb.items_seen, settings_used);
        $display("%0d wheel commands matched, %0d mismatched, %0d never arrived.",
                 sb.cmds_matched, sb.errors, sb.expected_cmds.size());
        if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
